// ===== rtl/pcbf_pkg.sv =====
// shared constants and types for the product-coordinate breadth-first distance fill
// sizes of the coordinate spaces, field widths, request codes and table port structs
// no dependencies
package pcbf_pkg;

	localparam int FIRST_MAX  = 4096;
	localparam int SECOND_MAX = 512;
	localparam int MOVES      = 18;

	localparam int OP_W   = 2;
	localparam int FC_W   = $clog2(FIRST_MAX);
	localparam int SC_W   = $clog2(SECOND_MAX);
	localparam int MV_W   = 5;
	localparam int DIST_W = 5;

	localparam int FCNT_W     = FC_W + 1;
	localparam int SCNT_W     = SC_W + 1;
	localparam int MCNT_W     = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	localparam int FT_DEPTH = FIRST_MAX * MOVES;
	localparam int FT_AW    = $clog2(FT_DEPTH);
	localparam int ST_DEPTH = SECOND_MAX * MOVES;
	localparam int ST_AW    = $clog2(ST_DEPTH);

	localparam int PAIRS  = FIRST_MAX * SECOND_MAX;
	localparam int PAIR_W = FC_W + SC_W;
	localparam int CNT_W  = PAIR_W + 1;

	localparam logic [DIST_W-1:0] UNREACHED = 5'd31;
	localparam logic [DIST_W-1:0] DIST_CAP  = 5'd30;

	localparam logic [OP_W-1:0] OP_LOAD_FIRST  = 2'd0;
	localparam logic [OP_W-1:0] OP_LOAD_SECOND = 2'd1;
	localparam logic [OP_W-1:0] OP_RUN         = 2'd2;
	localparam logic [OP_W-1:0] OP_READ        = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SECOND_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MOVE_COUNT   = 2'd2;

	typedef struct packed {
		logic            first_we;
		logic            second_we;
		logic [FC_W-1:0] first_coord;
		logic [SC_W-1:0] second_coord;
		logic [MV_W-1:0] move_index;
		logic [FC_W-1:0] next_coord;
	} tab_wr_t;

	typedef struct packed {
		logic [FC_W-1:0] first_coord;
		logic [SC_W-1:0] second_coord;
		logic [MV_W-1:0] move_index;
	} tab_rd_t;

	typedef struct packed {
		logic [FC_W-1:0] first_next;
		logic [SC_W-1:0] second_next;
	} tab_data_t;

endpackage

// ===== rtl/pcbf_move_tables.sv =====
// move-transition tables for both coordinates, one write and one registered read port each
// depends on pcbf_pkg
module pcbf_move_tables (
	input  logic                clk,
	input  pcbf_pkg::tab_wr_t   wr,
	input  pcbf_pkg::tab_rd_t   rd,
	output pcbf_pkg::tab_data_t rd_data
);
	import pcbf_pkg::*;

	logic [FC_W-1:0] first_mem  [FT_DEPTH];
	logic [SC_W-1:0] second_mem [ST_DEPTH];

	logic [FT_AW-1:0] first_wa, first_ra;
	logic [ST_AW-1:0] second_wa, second_ra;
	logic             move_ok;
	tab_data_t        rd_data_q;

	// row-major: coordinate times the maximum move count plus move
	assign first_wa  = FT_AW'(wr.first_coord) * FT_AW'(MOVES) + FT_AW'(wr.move_index);
	assign second_wa = ST_AW'(wr.second_coord) * ST_AW'(MOVES) + ST_AW'(wr.move_index);
	assign first_ra  = FT_AW'(rd.first_coord) * FT_AW'(MOVES) + FT_AW'(rd.move_index);
	assign second_ra = ST_AW'(rd.second_coord) * ST_AW'(MOVES) + ST_AW'(rd.move_index);
	assign move_ok   = wr.move_index < MV_W'(MOVES);

	always_ff @(posedge clk) begin
		if (wr.first_we && move_ok) begin
			first_mem[first_wa] <= wr.next_coord;
		end
		if (wr.second_we && move_ok) begin
			second_mem[second_wa] <= wr.next_coord[SC_W-1:0];
		end
		rd_data_q.first_next  <= first_mem[first_ra];
		rd_data_q.second_next <= second_mem[second_ra];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/product_coordinate_bfs_distance_fill_core.sv =====
// Breadth-first distance fill over (first, second) coordinate pairs. One request is in flight
// at a time, and a new one is taken only once the previous result has left the output or
// leaves in that same cycle. A run first sweeps the whole distance store, one entry a cycle,
// and then visits each reached pair once: it pops the pair from the frontier queue, then for
// each move reads the transition tables and, if the successor is in range, probes the
// distance store, all through the single read port of the transition tables and of the
// distance store; at last it finds the queue empty and posts the result. Reads before the
// first run return unreached.
// Depends on pcbf_pkg and pcbf_move_tables.
module product_coordinate_bfs_distance_fill_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [pcbf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pcbf_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [pcbf_pkg::OP_W-1:0]        operation,
	input  logic [pcbf_pkg::FC_W-1:0]        first_coord,
	input  logic [pcbf_pkg::SC_W-1:0]        second_coord,
	input  logic [pcbf_pkg::MV_W-1:0]        move_index,
	input  logic [pcbf_pkg::FC_W-1:0]        next_coord,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [pcbf_pkg::DIST_W-1:0]      distance,
	output logic [pcbf_pkg::CNT_W-1:0]       filled_count,
	output logic [pcbf_pkg::DIST_W-1:0]      max_depth,
	output logic                             run_done
);
	import pcbf_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_READ   = 9'b000000010,
		S_CLEAR  = 9'b000000100,
		S_POP    = 9'b000001000,
		S_FETCH  = 9'b000010000,
		S_TREQ   = 9'b000100000,
		S_TCHK   = 9'b001000000,
		S_DCHK   = 9'b010000000,
		S_FINISH = 9'b100000000
	} state_t;

	state_t state_q;

	logic [FCNT_W-1:0] first_count_q, nf, nf_q;
	logic [SCNT_W-1:0] second_count_q, ns, ns_q;
	logic [MCNT_W-1:0] move_count_q, nm, nm_q;

	logic [CNT_W-1:0]  head_q, tail_q, level_end_q;
	logic [DIST_W-1:0] level_q, deep_q, lvl_next;
	logic [PAIR_W-1:0] clr_q, cur_q, cand_q, cand;
	logic [MCNT_W-1:0] m_q;
	logic              run_seen_q;

	logic              out_valid_q, out_run_done_q;
	logic [DIST_W-1:0] out_distance_q, out_max_depth_q;
	logic [CNT_W-1:0]  out_filled_q;

	logic [DIST_W-1:0] dist_mem [PAIRS];
	logic [PAIR_W-1:0] queue_mem [PAIRS];
	logic [DIST_W-1:0] dist_rd_q, dist_wd;
	logic [PAIR_W-1:0] queue_rd_q, dist_wa, dist_ra, queue_wa, queue_wd;
	logic              dist_we, queue_we;

	logic      in_acc, run_acc, hit, last_move, first_ok, second_ok, out_load;
	tab_wr_t   tab_wr;
	tab_rd_t   tab_rd;
	tab_data_t tab_data;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign in_acc    = in_valid && in_ready;
	assign run_acc   = in_acc && (operation == OP_RUN);

	// counts in use, clamped to 1..max
	always_comb begin
		if (first_count_q == '0) nf = FCNT_W'(1);
		else if (first_count_q > FCNT_W'(FIRST_MAX)) nf = FCNT_W'(FIRST_MAX);
		else nf = first_count_q;
		if (second_count_q == '0) ns = SCNT_W'(1);
		else if (second_count_q > SCNT_W'(SECOND_MAX)) ns = SCNT_W'(SECOND_MAX);
		else ns = second_count_q;
		if (move_count_q == '0) nm = MCNT_W'(1);
		else if (move_count_q > MCNT_W'(MOVES)) nm = MCNT_W'(MOVES);
		else nm = move_count_q;
	end

	assign tab_wr.first_we     = in_acc && (operation == OP_LOAD_FIRST);
	assign tab_wr.second_we    = in_acc && (operation == OP_LOAD_SECOND);
	assign tab_wr.first_coord  = first_coord;
	assign tab_wr.second_coord = second_coord;
	assign tab_wr.move_index   = move_index;
	assign tab_wr.next_coord   = next_coord;

	assign tab_rd.first_coord  = cur_q[PAIR_W-1:SC_W];
	assign tab_rd.second_coord = cur_q[SC_W-1:0];
	assign tab_rd.move_index   = m_q;

	pcbf_move_tables u_tables (
		.clk     (clk),
		.wr      (tab_wr),
		.rd      (tab_rd),
		.rd_data (tab_data)
	);

	assign cand      = {tab_data.first_next, tab_data.second_next};
	assign first_ok  = {1'b0, tab_data.first_next} < nf_q;
	assign second_ok = {1'b0, tab_data.second_next} < ns_q;
	assign hit       = (state_q == S_DCHK) && (dist_rd_q == UNREACHED);
	assign last_move = m_q == (nm_q - MCNT_W'(1));
	assign lvl_next  = (level_q >= DIST_CAP) ? DIST_CAP : level_q + DIST_W'(1);

	// distance store: sweep writes, new distances, one read port shared by read requests and probes
	assign dist_we = (state_q == S_CLEAR) || hit;
	assign dist_wa = (state_q == S_CLEAR) ? clr_q : cand_q;
	assign dist_wd = (state_q == S_CLEAR) ? ((clr_q == '0) ? '0 : UNREACHED) : lvl_next;
	assign dist_ra = (state_q == S_IDLE) ? {first_coord, second_coord} : cand;

	always_ff @(posedge clk) begin
		if (dist_we) begin
			dist_mem[dist_wa] <= dist_wd;
		end
		dist_rd_q <= dist_mem[dist_ra];
	end

	// frontier queue: origin seeded at run start, newly reached pairs appended at tail
	assign queue_we = run_acc || hit;
	assign queue_wa = hit ? tail_q[PAIR_W-1:0] : '0;
	assign queue_wd = hit ? cand_q : '0;

	always_ff @(posedge clk) begin
		if (queue_we) begin
			queue_mem[queue_wa] <= queue_wd;
		end
		queue_rd_q <= queue_mem[head_q[PAIR_W-1:0]];
	end

	assign out_load = (in_acc && (operation == OP_LOAD_FIRST || operation == OP_LOAD_SECOND))
		|| (state_q == S_READ) || (state_q == S_FINISH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			first_count_q  <= FCNT_W'(2048);
			second_count_q <= SCNT_W'(495);
			move_count_q   <= MCNT_W'(18);
			nf_q           <= '0;
			ns_q           <= '0;
			nm_q           <= '0;
			head_q         <= '0;
			tail_q         <= '0;
			level_end_q    <= '0;
			level_q        <= '0;
			deep_q         <= '0;
			clr_q          <= '0;
			m_q            <= '0;
			run_seen_q     <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_FIRST_COUNT:  first_count_q  <= cfg_data[FCNT_W-1:0];
					CFG_SECOND_COUNT: second_count_q <= cfg_data[SCNT_W-1:0];
					CFG_MOVE_COUNT:   move_count_q   <= cfg_data[MCNT_W-1:0];
					default: ;
				endcase
			end

			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (run_acc) begin
						nf_q        <= nf;
						ns_q        <= ns;
						nm_q        <= nm;
						head_q      <= '0;
						tail_q      <= CNT_W'(1);
						level_end_q <= CNT_W'(1);
						level_q     <= '0;
						deep_q      <= '0;
						clr_q       <= '0;
						state_q     <= S_CLEAR;
					end else if (in_acc && operation == OP_READ) begin
						state_q <= S_READ;
					end
				end
				S_READ: state_q <= S_IDLE;
				S_CLEAR: begin
					clr_q <= clr_q + PAIR_W'(1);
					if (clr_q == '1) state_q <= S_POP;
				end
				S_POP: begin
					if (head_q == tail_q) begin
						state_q <= S_FINISH;
					end else begin
						// first pair of a new level
						if (head_q == level_end_q) begin
							level_q     <= lvl_next;
							level_end_q <= tail_q;
						end
						head_q  <= head_q + CNT_W'(1);
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					m_q     <= '0;
					state_q <= S_TREQ;
				end
				S_TREQ: state_q <= S_TCHK;
				S_TCHK: begin
					if (first_ok && second_ok) state_q <= S_DCHK;
					else if (last_move) state_q <= S_POP;
					else begin
						m_q     <= m_q + MCNT_W'(1);
						state_q <= S_TREQ;
					end
				end
				S_DCHK: begin
					if (hit) begin
						tail_q <= tail_q + CNT_W'(1);
						if (lvl_next > deep_q) deep_q <= lvl_next;
					end
					if (last_move) state_q <= S_POP;
					else begin
						m_q     <= m_q + MCNT_W'(1);
						state_q <= S_TREQ;
					end
				end
				S_FINISH: begin
					run_seen_q <= 1'b1;
					state_q    <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_FETCH) cur_q <= queue_rd_q;
		if (state_q == S_TCHK) cand_q <= cand;
		if (out_load) begin
			out_filled_q    <= tail_q;
			out_max_depth_q <= deep_q;
			out_run_done_q  <= state_q == S_FINISH;
			if (state_q == S_READ) out_distance_q <= run_seen_q ? dist_rd_q : UNREACHED;
			else out_distance_q <= '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign distance     = out_distance_q;
	assign filled_count = out_filled_q;
	assign max_depth    = out_max_depth_q;
	assign run_done     = out_run_done_q;

	a_run_starts_clear: assert property (@(posedge clk) disable iff (!arst_n)
		run_acc |=> state_q == S_CLEAR)
		else $error("run request did not start the store sweep");

	a_queue_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_POP |-> head_q <= level_end_q && level_end_q <= tail_q)
		else $error("frontier pointers out of order");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tail_q <= CNT_W'(PAIRS))
		else $error("frontier queue overran the pair space");

	a_finish_posts: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FINISH |=> out_valid && run_done && state_q == S_IDLE)
		else $error("finished run not posted at the output");

endmodule
